// File: hw/rtl/bvd_pkg.sv
`default_nettype none
package bvd_pkg;

	// operand width the divider is built for
	localparam int DIV_WIDTH = 32;

	// stream payload layout
	localparam int OP_W        = 2;
	localparam int DATA_W      = 32;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 32;

	localparam int OP_LSB  = 0;
	localparam int DVD_LSB = OP_LSB + OP_W;
	localparam int DVS_LSB = DVD_LSB + DATA_W;

	// operation codes
	localparam logic [OP_W-1:0] OP_UDIV = 2'd0;
	localparam logic [OP_W-1:0] OP_SDIV = 2'd1;
	localparam logic [OP_W-1:0] OP_UREM = 2'd2;
	localparam logic [OP_W-1:0] OP_SREM = 2'd3;

	// per-beat control that rides along the cell chain
	typedef struct packed {
		logic rem_sel;  // deliver remainder instead of quotient
		logic neg;      // negate the unsigned result at the end
	} ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/bitvector_divider_smtlib.sv
// an accepted input beat passes the prep register, the WIDTH divide cells and the output register
// throughput: one beat per cycle while the output side is ready, set by the chain of WIDTH divide cells
// each stage holds its own valid bit, so bubbles close up under backpressure
// reset: arst_n low clears every stage valid bit at once, no payload is cleared
`default_nettype none
module bitvector_divider_smtlib #(
	parameter int WIDTH = bvd_pkg::DIV_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output      logic                            s_tready,
	// op [1:0], dividend [33:2], divisor [65:34], zero pad [71:66]
	input  wire logic [bvd_pkg::IN_TDATA_W-1:0]  s_tdata,
	output      logic                            m_tvalid,
	input  wire logic                            m_tready,
	// result [31:0]
	output      logic [bvd_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import bvd_pkg::*;

	// payload fields of the input beat; operand bits above WIDTH drop off
	logic [OP_W-1:0]  op;
	logic [WIDTH-1:0] dvd;
	logic [WIDTH-1:0] dvs;

	assign op  = s_tdata[OP_LSB +: OP_W];
	assign dvd = WIDTH'(s_tdata[DVD_LSB +: DATA_W]);
	assign dvs = WIDTH'(s_tdata[DVS_LSB +: DATA_W]);

	// link k feeds cell k; link WIDTH feeds the fix-up stage
	logic [WIDTH:0]   lnk_valid;
	logic [WIDTH:0]   lnk_ready;
	ctl_t             lnk_ctl [WIDTH+1];
	logic [WIDTH-1:0] lnk_rem [WIDTH+1];
	logic [WIDTH-1:0] lnk_quo [WIDTH+1];
	logic [WIDTH-1:0] lnk_dvs [WIDTH+1];
	logic [WIDTH-1:0] res;

	// sign handling and operand magnitudes
	bvd_prep #(
		.WIDTH(WIDTH)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (op),
		.in_dvd   (dvd),
		.in_dvs   (dvs),
		.out_valid(lnk_valid[0]),
		.out_ready(lnk_ready[0]),
		.out_ctl  (lnk_ctl[0]),
		.out_dvd  (lnk_quo[0]),
		.out_dvs  (lnk_dvs[0])
	);

	// the partial remainder starts empty; the dividend sits in the quotient shifter
	assign lnk_rem[0] = '0;

	// one cell per quotient bit, most significant first; a zero divisor
	// naturally yields all-ones quotient and the dividend as remainder,
	// and the most negative value over minus one wraps, as its magnitude is itself
	for (genvar k = 0; k < WIDTH; k++) begin : g_cell
		bvd_cell #(
			.WIDTH(WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (lnk_valid[k]),
			.in_ready (lnk_ready[k]),
			.in_ctl   (lnk_ctl[k]),
			.in_rem   (lnk_rem[k]),
			.in_quo   (lnk_quo[k]),
			.in_dvs   (lnk_dvs[k]),
			.out_valid(lnk_valid[k+1]),
			.out_ready(lnk_ready[k+1]),
			.out_ctl  (lnk_ctl[k+1]),
			.out_rem  (lnk_rem[k+1]),
			.out_quo  (lnk_quo[k+1]),
			.out_dvs  (lnk_dvs[k+1])
		);
	end

	// result select, sign fix-up and output register
	bvd_post #(
		.WIDTH(WIDTH)
	) u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (lnk_valid[WIDTH]),
		.in_ready (lnk_ready[WIDTH]),
		.in_ctl   (lnk_ctl[WIDTH]),
		.in_rem   (lnk_rem[WIDTH]),
		.in_quo   (lnk_quo[WIDTH]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	// zero above WIDTH, cut to the port when WIDTH is wider
	assign m_tdata = OUT_TDATA_W'(res);

endmodule
`default_nettype wire

// File: hw/rtl/bvd_prep.sv
`default_nettype none
module bvd_prep #(
	parameter int WIDTH = bvd_pkg::DIV_WIDTH
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output      logic                    in_ready,
	input  wire logic [bvd_pkg::OP_W-1:0] in_op,
	input  wire logic [WIDTH-1:0]        in_dvd,
	input  wire logic [WIDTH-1:0]        in_dvs,
	output      logic                    out_valid,
	input  wire logic                    out_ready,
	output      bvd_pkg::ctl_t           out_ctl,
	output      logic [WIDTH-1:0]        out_dvd,
	output      logic [WIDTH-1:0]        out_dvs
);
	import bvd_pkg::*;

	logic             is_signed;
	logic             is_rem;
	logic             dvd_neg;
	logic             dvs_neg;
	ctl_t             ctl_d;
	logic [WIDTH-1:0] dvd_mag;
	logic [WIDTH-1:0] dvs_mag;
	logic             valid_q;
	ctl_t             ctl_q;
	logic [WIDTH-1:0] dvd_q;
	logic [WIDTH-1:0] dvs_q;

	always_comb begin
		unique case (in_op)
			OP_UDIV: begin
				is_signed = 1'b0;
				is_rem    = 1'b0;
			end
			OP_SDIV: begin
				is_signed = 1'b1;
				is_rem    = 1'b0;
			end
			OP_UREM: begin
				is_signed = 1'b0;
				is_rem    = 1'b1;
			end
			OP_SREM: begin
				is_signed = 1'b1;
				is_rem    = 1'b1;
			end
			default: begin
				is_signed = 1'b0;
				is_rem    = 1'b0;
			end
		endcase
	end

	assign dvd_neg = is_signed & in_dvd[WIDTH-1];
	assign dvs_neg = is_signed & in_dvs[WIDTH-1];
	assign dvd_mag = dvd_neg ? (~in_dvd + WIDTH'(1)) : in_dvd;
	assign dvs_mag = dvs_neg ? (~in_dvs + WIDTH'(1)) : in_dvs;

	// remainder follows the dividend, quotient the sign product
	assign ctl_d.rem_sel = is_rem;
	assign ctl_d.neg     = is_rem ? dvd_neg : (dvd_neg ^ dvs_neg);

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctl_q <= ctl_d;
			dvd_q <= dvd_mag;
			dvs_q <= dvs_mag;
		end
	end

	assign out_valid = valid_q;
	assign out_ctl   = ctl_q;
	assign out_dvd   = dvd_q;
	assign out_dvs   = dvs_q;

endmodule
`default_nettype wire

// File: hw/rtl/bvd_cell.sv
`default_nettype none
module bvd_cell #(
	parameter int WIDTH = bvd_pkg::DIV_WIDTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output      logic             in_ready,
	input  wire bvd_pkg::ctl_t    in_ctl,
	input  wire logic [WIDTH-1:0] in_rem,
	input  wire logic [WIDTH-1:0] in_quo,
	input  wire logic [WIDTH-1:0] in_dvs,
	output      logic             out_valid,
	input  wire logic             out_ready,
	output      bvd_pkg::ctl_t    out_ctl,
	output      logic [WIDTH-1:0] out_rem,
	output      logic [WIDTH-1:0] out_quo,
	output      logic [WIDTH-1:0] out_dvs
);
	import bvd_pkg::*;

	logic [WIDTH+1:0] diff;
	logic             fits;
	logic [WIDTH-1:0] rem_d;
	logic [WIDTH-1:0] quo_d;
	logic             valid_q;
	ctl_t             ctl_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dvs_q;

	// one restoring step: shift in the next dividend bit, try the subtract
	assign diff  = {1'b0, in_rem, in_quo[WIDTH-1]} - {2'b00, in_dvs};
	assign fits  = !diff[WIDTH+1];
	assign rem_d = fits ? diff[WIDTH-1:0] : {in_rem[WIDTH-2:0], in_quo[WIDTH-1]};
	assign quo_d = {in_quo[WIDTH-2:0], fits};

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctl_q <= in_ctl;
			rem_q <= rem_d;
			quo_q <= quo_d;
			dvs_q <= in_dvs;
		end
	end

	assign out_valid = valid_q;
	assign out_ctl   = ctl_q;
	assign out_rem   = rem_q;
	assign out_quo   = quo_q;
	assign out_dvs   = dvs_q;

endmodule
`default_nettype wire

// File: hw/rtl/bvd_post.sv
`default_nettype none
module bvd_post #(
	parameter int WIDTH = bvd_pkg::DIV_WIDTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output      logic             in_ready,
	input  wire bvd_pkg::ctl_t    in_ctl,
	input  wire logic [WIDTH-1:0] in_rem,
	input  wire logic [WIDTH-1:0] in_quo,
	output      logic             out_valid,
	input  wire logic             out_ready,
	output      logic [WIDTH-1:0] out_res
);
	import bvd_pkg::*;

	logic [WIDTH-1:0] mag;
	logic [WIDTH-1:0] res_d;
	logic             valid_q;
	logic [WIDTH-1:0] res_q;

	assign mag   = in_ctl.rem_sel ? in_rem : in_quo;
	assign res_d = in_ctl.neg ? (~mag + WIDTH'(1)) : mag;

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= res_d;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule
`default_nettype wire

// File: hw/rtl/bvd_checker.sv
`default_nettype none
module bvd_checker #(
	parameter int WIDTH = bvd_pkg::DIV_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	input  wire logic                            s_tready,
	input  wire logic                            m_tvalid,
	input  wire logic                            m_tready,
	input  wire logic [bvd_pkg::OUT_TDATA_W-1:0] m_tdata
);
	localparam int DEPTH = WIDTH + 2;
	localparam int CNT_W = $clog2(DEPTH + 1) + 1;

	logic             acc_in;
	logic             acc_out;
	logic [CNT_W-1:0] cnt_q;

	assign acc_in  = s_tvalid && s_tready;
	assign acc_out = m_tvalid && m_tready;

	// beats inside the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(acc_in) - CNT_W'(acc_out);
		end
	end

	// no output beat without an input beat behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt_q != '0)
		else $error("output beat with nothing in flight");

	// never more in flight than the chain has stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("more beats in flight than stages");

	// a free output side lets the input side through
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output is ready");

	// an empty block takes a beat
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> s_tready)
		else $error("empty block not ready");

	// a stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output beat changed");

endmodule

bind bitvector_divider_smtlib bvd_checker #(
	.WIDTH(WIDTH)
) u_bvd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire

// File: dv/bvd_div_monitor.sv
`default_nettype none
module bvd_div_monitor #(
	parameter int WIDTH = bvd_pkg::DIV_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	input  wire logic                            s_tready,
	// op [1:0], dividend [33:2], divisor [65:34], zero pad [71:66]
	input  wire logic [bvd_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                            m_tvalid,
	input  wire logic                            m_tready,
	// result [31:0]
	input  wire logic [bvd_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                                   mismatches,
	output int                                   pending
);
	import bvd_pkg::*;

	typedef struct {
		logic [OP_W-1:0]        op;
		logic [DATA_W-1:0]      dvd;
		logic [DATA_W-1:0]      dvs;
		logic [OUT_TDATA_W-1:0] res;
	} div_job_t;

	div_job_t results_due[$];
	int       bad_beats = 0;

	// smt-lib division rules at WIDTH bits, zero above
	function automatic logic [OUT_TDATA_W-1:0] bv_div_result(
		input logic [OP_W-1:0] op,
		input logic [WIDTH-1:0] a,
		input logic [WIDTH-1:0] b
	);
		logic             a_neg;
		logic             b_neg;
		logic [WIDTH-1:0] a_mag;
		logic [WIDTH-1:0] b_mag;
		logic [WIDTH-1:0] mag;
		logic [WIDTH-1:0] all_ones;
		logic [WIDTH-1:0] r;
		a_neg    = a[WIDTH-1];
		b_neg    = b[WIDTH-1];
		a_mag    = a_neg ? ~a + WIDTH'(1) : a;
		b_mag    = b_neg ? ~b + WIDTH'(1) : b;
		all_ones = '1;
		case (op)
			OP_UDIV: r = (b == '0) ? all_ones : a / b;
			OP_UREM: r = (b == '0) ? a : a % b;
			OP_SDIV: begin
				if (b == '0) begin
					r = a_neg ? {{(WIDTH-1){1'b0}}, 1'b1} : all_ones;
				end else begin
					mag = a_mag / b_mag;
					r   = (a_neg != b_neg) ? ~mag + WIDTH'(1) : mag;
				end
			end
			default: begin
				if (b == '0) begin
					r = a;
				end else begin
					mag = a_mag % b_mag;
					r   = a_neg ? ~mag + WIDTH'(1) : mag;
				end
			end
		endcase
		return OUT_TDATA_W'(r);
	endfunction

	always @(posedge clk) begin
		div_job_t job;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				job.op  = s_tdata[OP_LSB +: OP_W];
				job.dvd = s_tdata[DVD_LSB +: DATA_W];
				job.dvs = s_tdata[DVS_LSB +: DATA_W];
				job.res = bv_div_result(job.op, job.dvd[WIDTH-1:0], job.dvs[WIDTH-1:0]);
				results_due.insert(results_due.size(), job);
			end
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					bad_beats++;
					if (bad_beats <= 10)
						$display("unexpected result beat %h", m_tdata);
				end else begin
					job = results_due.pop_front();
					if (m_tdata !== job.res) begin
						bad_beats++;
						if (bad_beats <= 10)
							$display("op %0d %h / %h: result expected %h got %h",
								job.op, job.dvd, job.dvs, job.res, m_tdata);
					end
				end
			end
			mismatches <= bad_beats;
			pending    <= results_due.size();
		end
	end

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none
module tb_top;
	import bvd_pkg::*;

	// cycles without any beat before the run is declared hung
	localparam int STUCK_LIMIT = 3000;
	// pipeline depth of the divider
	localparam int LATENCY     = DIV_WIDTH + 2;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// op [1:0], dividend [33:2], divisor [65:34], zero pad [71:66]
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// result [31:0]
	logic [OUT_TDATA_W-1:0] m_tdata;

	int mismatches;
	int pending;
	int stuck_cycles = 0;
	int sink_left    = 0;
	// calm stretches: no gaps on either side
	bit calm         = 1'b0;

	always #4 clk = ~clk;

	bitvector_divider_smtlib dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// watches both channels, predicts every result and counts mismatches
	bvd_div_monitor div_mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// hang detection: any accepted beat on either side resets the count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// result side backpressure: mostly ready, short stalls, a few long ones
	always @(posedge clk) begin
		int r;
		if (sink_left > 0) begin
			sink_left--;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				m_tready  <= 1'b1;
				sink_left = $urandom_range(0, 7);
			end else if (r < 90) begin
				m_tready  <= 1'b0;
				sink_left = $urandom_range(0, 2);
			end else begin
				m_tready  <= 1'b0;
				sink_left = $urandom_range(10, 40);
			end
		end
	end

	// idle cycles before the next input beat
	function automatic int beat_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// operand mix: zeros, units, sign extremes, scaled magnitudes, full random
	function automatic logic [DATA_W-1:0] pick_operand(input bit for_divisor);
		int                r;
		logic [DATA_W-1:0] v;
		r = $urandom_range(0, 99);
		if (for_divisor && r < 12) begin
			v = '0;
		end else if (r < 20) begin
			case ($urandom_range(0, 3))
				0: v = 32'h0000_0001;
				1: v = 32'hFFFF_FFFF;
				2: v = 32'h0000_0002;
				default: v = 32'hFFFF_FFFE;
			endcase
		end else if (r < 28) begin
			case ($urandom_range(0, 3))
				0: v = 32'h8000_0000;
				1: v = 32'h7FFF_FFFF;
				2: v = 32'hFFFF_FFFF;
				default: v = '0;
			endcase
		end else if (r < 60) begin
			// spread magnitudes so quotients are not just 0 or 1
			v = $urandom() >> $urandom_range(0, 31);
			if ($urandom_range(0, 1))
				v = ~v + DATA_W'(1);
		end else begin
			v = $urandom();
		end
		return v;
	endfunction

	// present one division and hold it until the divider takes it
	task automatic send_division(
		input logic [OP_W-1:0]   op,
		input logic [DATA_W-1:0] dvd,
		input logic [DATA_W-1:0] dvs
	);
		int                    gap;
		logic [IN_TDATA_W-1:0] beat;
		gap  = beat_gap();
		beat = '0;
		beat[OP_LSB +: OP_W]    = op;
		beat[DVD_LSB +: DATA_W] = dvd;
		beat[DVS_LSB +: DATA_W] = dvs;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= beat;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	initial begin
		int                i;
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] dvd;
		logic [DATA_W-1:0] dvs;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unsigned divide: largest values, divide by zero, zero dividend
		send_division(OP_UDIV, 32'hFFFF_FFFF, 32'h0000_0001);
		send_division(OP_UDIV, 32'h1234_5678, 32'h0000_0000);
		send_division(OP_UDIV, 32'h0000_0000, 32'hFFFF_FFFF);
		send_division(OP_UDIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_division(OP_UDIV, 32'h8000_0000, 32'hFFFF_FFFF);
		// signed divide: overflow wrap, zero divisor for both dividend signs,
		// truncation toward zero with either or both operands negative
		send_division(OP_SDIV, 32'h8000_0000, 32'hFFFF_FFFF);
		send_division(OP_SDIV, 32'h0000_0005, 32'h0000_0000);
		send_division(OP_SDIV, 32'h8000_0000, 32'h0000_0000);
		send_division(OP_SDIV, 32'hFFFF_FFF9, 32'h0000_0002);
		send_division(OP_SDIV, 32'h0000_0007, 32'hFFFF_FFFE);
		send_division(OP_SDIV, 32'hFFFF_FFF9, 32'hFFFF_FFFE);
		send_division(OP_SDIV, 32'h7FFF_FFFF, 32'h8000_0000);
		// unsigned remainder: by zero returns the dividend
		send_division(OP_UREM, 32'hDEAD_BEEF, 32'h0000_0000);
		send_division(OP_UREM, 32'hFFFF_FFFF, 32'h0000_0010);
		send_division(OP_UREM, 32'h0000_0000, 32'h0000_0003);
		// signed remainder: overflow case is zero, sign follows the dividend
		send_division(OP_SREM, 32'h8000_0000, 32'hFFFF_FFFF);
		send_division(OP_SREM, 32'hFFFF_FFF9, 32'h0000_0002);
		send_division(OP_SREM, 32'h0000_0007, 32'hFFFF_FFFE);
		send_division(OP_SREM, 32'hFFFF_FFF9, 32'hFFFF_FFFE);
		send_division(OP_SREM, 32'h8000_0000, 32'h0000_0000);
		send_division(OP_SREM, 32'h7FFF_FFFF, 32'h8000_0000);
		send_division(OP_SREM, 32'h8000_0000, 32'h7FFF_FFFF);

		// random operations, every third block of fifty runs with no gaps
		for (i = 0; i < 400; i++) begin
			calm = ((i / 50) % 3) == 2;
			op   = OP_W'($urandom_range(0, 3));
			dvd  = pick_operand(1'b0);
			dvs  = pick_operand(1'b1);
			send_division(op, dvd, dvs);
		end
		calm = 1'b0;

		s_tvalid <= 1'b0;
		@(posedge clk);
		// drain: the watchdog bounds this wait
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
`default_nettype wire
